@@ hdl/smph_pkg.sv @@
package smph_pkg;

    localparam int unsigned ADC_W      = 12;
    localparam int unsigned LEVEL_W    = 15;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned SAMPLES_DEF = 8;

    // Shared divider: dividend covers the scaled numerator, divisor the calibration span
    localparam int unsigned DIV_W      = 27;
    localparam int unsigned DVS_W      = ADC_W;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd25600;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_BELOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_AT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY    = 3'd5;

    // Pump modes
    localparam logic [MODE_W-1:0] MODE_AUTO       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORCED_ON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORCED_OFF = 2'd2;

    // Reset values
    localparam logic [ADC_W-1:0]   WET_RST      = 12'd1500;
    localparam logic [ADC_W-1:0]   DRY_RST      = 12'd4095;
    localparam logic [LEVEL_W-1:0] ON_BELOW_RST = 15'd8960;
    localparam logic [LEVEL_W-1:0] OFF_AT_RST   = 15'd15360;

    typedef struct packed {
        logic [ADC_W-1:0]   wet;
        logic [ADC_W-1:0]   dry;
        logic [LEVEL_W-1:0] on_below;
        logic [LEVEL_W-1:0] off_at;
        logic [MODE_W-1:0]  mode;
        logic               relay_level;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hdl/smph_div.sv @@
module smph_div
    import smph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W:0]       r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] rem_sh;
    logic           ge;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
    assign rem_sh = {r_rem[DVS_W-1:0], r_quo[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hdl/smph_seq.sv @@
module smph_seq
    import smph_pkg::*;
#(
    parameter int unsigned SAMPLES = SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ADC_W-1:0]   i_adc_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LEVEL_W-1:0] o_moisture_level,
    output logic               o_pump_on,
    output logic               o_relay_drive,
    output logic               o_calibration_error
);

    localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_CLAMP,
        S_MUL,
        S_DIVST,
        S_DIV,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;
    logic [ADC_W-1:0]     r_avg;
    logic [ADC_W-1:0]     r_num;
    logic [ADC_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_prod;
    logic [LEVEL_W-1:0]   r_moist;
    logic                 r_err;
    logic                 r_pump;
    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_out_moist;
    logic                 r_out_pump;
    logic                 r_out_relay;
    logic                 r_out_err;

    logic               accept;
    logic               last_sample;
    logic [SUM_W-1:0]   n_sum;
    logic [ADC_W-1:0]   lo;
    logic [ADC_W-1:0]   hi;
    logic [ADC_W-1:0]   clamped;
    logic               out_free;
    logic               load_out;
    logic               n_pump;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign last_sample = r_cnt == CNT_W'(SAMPLES - 1);
    assign n_sum       = r_sum + SUM_W'(i_adc_sample);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == S_OUT) && out_free;

    assign lo      = (i_cfg.wet < i_cfg.dry) ? i_cfg.wet : i_cfg.dry;
    assign hi      = (i_cfg.wet < i_cfg.dry) ? i_cfg.dry : i_cfg.wet;
    assign clamped = (r_avg < lo) ? lo : ((r_avg > hi) ? hi : r_avg);

    // Share one divider: the batch average first, then the scaled moisture ratio
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(n_sum);
        div_req.divisor  = DVS_W'(SAMPLES);
        if (r_state == S_IDLE) begin
            div_req.start = accept && last_sample;
        end else if (r_state == S_DIVST) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_prod;
            div_req.divisor  = r_den;
        end
    end

    always_comb begin
        n_pump = r_pump;
        case (i_cfg.mode)
            MODE_FORCED_ON:  n_pump = 1'b1;
            MODE_FORCED_OFF: n_pump = 1'b0;
            default: begin
                if (r_moist < i_cfg.on_below) begin
                    n_pump = 1'b1;
                end else if (r_moist >= i_cfg.off_at) begin
                    n_pump = 1'b0;
                end
            end
        endcase
    end

    smph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_pump      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (last_sample) begin
                            r_sum   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_AVG;
                        end else begin
                            r_sum <= n_sum;
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_AVG: begin
                    if (div_rsp.done) begin
                        // The average never exceeds the largest sample
                        r_avg <= div_rsp.quotient[ADC_W-1:0];
                        if (i_cfg.wet == i_cfg.dry) begin
                            r_moist <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= S_CLAMP;
                        end
                    end
                end
                S_CLAMP: begin
                    r_num   <= (clamped >= i_cfg.wet) ? (clamped - i_cfg.wet)
                                                      : (i_cfg.wet - clamped);
                    r_den   <= (i_cfg.dry >= i_cfg.wet) ? (i_cfg.dry - i_cfg.wet)
                                                        : (i_cfg.wet - i_cfg.dry);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= DIV_W'(r_num) * DIV_W'(FULL_SCALE);
                    r_state <= S_DIVST;
                end
                S_DIVST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient > DIV_W'(FULL_SCALE)) begin
                            r_moist <= '0;
                        end else begin
                            r_moist <= FULL_SCALE - div_rsp.quotient[LEVEL_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold the result until the output register is free
                    if (out_free) begin
                        r_pump      <= n_pump;
                        r_out_moist <= r_moist;
                        r_out_pump  <= n_pump;
                        r_out_relay <= n_pump ? i_cfg.relay_level : !i_cfg.relay_level;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall          = r_state != S_IDLE;
    assign o_out_valid         = r_out_valid;
    assign o_moisture_level    = r_out_moist;
    assign o_pump_on           = r_out_pump;
    assign o_relay_drive       = r_out_relay;
    assign o_calibration_error = r_out_err;

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_AVG || r_state == S_DIV))
        else $error("divider finished outside a wait state");

    a_moist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_moist <= FULL_SCALE))
        else $error("moisture above full scale");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_moist == '0))
        else $error("calibration error with nonzero moisture");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(SAMPLES))
        else $error("sample count beyond batch size");

    a_relay_polarity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_relay == (r_out_pump ~^ i_cfg.relay_level)))
        else $error("relay level does not match pump command");

endmodule

@@ hdl/soil_moisture_pump_hysteresis.sv @@
// Soil moisture pump controller with averaging and hysteresis.
// Input channel: i_in_valid / o_in_stall carry one 12-bit converter sample per
// transaction. Every SAMPLES transactions the batch average is clamped to the
// wet/dry calibration span, mapped to moisture (percent * 256, 25600 = wet)
// and a pump command is produced on the output channel (o_out_valid /
// i_out_stall). Other transactions give no result.
// Stalls: a non-final sample is taken without stalling the input. The final
// sample of a batch keeps the input stalled until its result is loaded into
// the output register: two passes of the shared bit-serial divider (average,
// then moisture ratio) plus clamp, multiply, divider start and output load.
// An equal wet/dry pair skips the second pass and flags calibration_error
// with moisture 0.
// The output register holds a result until taken; a new batch may start
// while it waits, and the block stalls at the end of that batch only if the
// receiver still has not taken the previous result.
// Reset (synchronous, active low) clears the partial sum, sample count, pump
// state and output valid, and restores the calibration and threshold
// registers to their defaults. Write registers only while idle.
module soil_moisture_pump_hysteresis
    import smph_pkg::*;
#(
    parameter int unsigned SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADC_W-1:0]      i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LEVEL_W-1:0]    o_moisture_level,
    output logic                  o_pump_on,
    output logic                  o_relay_drive,
    output logic                  o_calibration_error
);

    t_cfg r_cfg;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wet         <= WET_RST;
            r_cfg.dry         <= DRY_RST;
            r_cfg.on_below    <= ON_BELOW_RST;
            r_cfg.off_at      <= OFF_AT_RST;
            r_cfg.mode        <= MODE_AUTO;
            r_cfg.relay_level <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WET:      r_cfg.wet         <= i_cfg_data[ADC_W-1:0];
                REG_DRY:      r_cfg.dry         <= i_cfg_data[ADC_W-1:0];
                REG_ON_BELOW: r_cfg.on_below    <= i_cfg_data[LEVEL_W-1:0];
                REG_OFF_AT:   r_cfg.off_at      <= i_cfg_data[LEVEL_W-1:0];
                REG_MODE:     r_cfg.mode        <= i_cfg_data[MODE_W-1:0];
                REG_RELAY:    r_cfg.relay_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer, shared divider and output register
    smph_seq #(
        .SAMPLES (SAMPLES)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_adc_sample        (i_adc_sample),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_moisture_level    (o_moisture_level),
        .o_pump_on           (o_pump_on),
        .o_relay_drive       (o_relay_drive),
        .o_calibration_error (o_calibration_error)
    );

endmodule
